// ===== hdl/mct_pkg.sv =====
`timescale 1ns / 1ps
package mct_pkg;

  localparam int unsigned MAX_DIM       = 4;
  localparam int unsigned DIM_DEF       = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam int unsigned ELEM_W = 32;
  localparam int unsigned COL_W  = 2;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W  = PROD_W + 2;

  // input queue between front and back
  localparam int unsigned IQ_DEPTH = 2;
  localparam int unsigned IQ_AW    = $clog2(IQ_DEPTH);

  // result queue at the output
  localparam int unsigned RQ_DEPTH = 4;
  localparam int unsigned RQ_AW    = $clog2(RQ_DEPTH);

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_XFORM = 1'b1;

  typedef enum logic {
    KIND_LOAD,
    KIND_XFORM
  } kind_e;

  typedef logic [MAX_DIM-1:0][ELEM_W-1:0] vec_t;

  typedef struct packed {
    kind_e            kind;
    logic [COL_W-1:0] column;
    vec_t             elem;
  } cmd_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    vec_t             res;
    logic             sat;
  } res_t;

endpackage

// ===== hdl/matrix_column_transform_4x4.sv =====
`timescale 1ns / 1ps
// column transform engine for column-major matrix products r = L * R, signed Q16.16
// input side is a queue: drive the item and raise push; it is taken at an edge where
// full is low. action 0 loads elem0..elem3 as column 'column' of L (no result),
// action 1 transforms the given column and yields one result item.
// result side is a queue: while empty is low the oldest result is on out_column,
// res0..res3 and saturated; raise pop to take it.
// path of a transform: input queue, multiply stage, pair-add stage, then sum/shift/clip
// into the result queue, from which it can be popped
// throughput: one item per cycle while pop keeps up, set by the 16 parallel multipliers
// a load writes L when taken, and a transform taken right after it sees the new column
// when pop stays low the result queue (4 deep) fills, the back end stops issuing
// transforms, the 2-deep input queue fills and full rises; nothing is dropped
// reset empties both queues and the pipeline; L is undefined until loaded
module matrix_column_transform_4x4 #(
  parameter int unsigned DIM       = mct_pkg::DIM_DEF,
  parameter int unsigned FRAC_BITS = mct_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic                       action_i,
  input  logic [mct_pkg::COL_W-1:0]  column_i,
  input  logic [mct_pkg::ELEM_W-1:0] elem0_i,
  input  logic [mct_pkg::ELEM_W-1:0] elem1_i,
  input  logic [mct_pkg::ELEM_W-1:0] elem2_i,
  input  logic [mct_pkg::ELEM_W-1:0] elem3_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [mct_pkg::COL_W-1:0]  out_column_o,
  output logic [mct_pkg::ELEM_W-1:0] res0_o,
  output logic [mct_pkg::ELEM_W-1:0] res1_o,
  output logic [mct_pkg::ELEM_W-1:0] res2_o,
  output logic [mct_pkg::ELEM_W-1:0] res3_o,
  output logic                       saturated_o
);
  import mct_pkg::*;

  vec_t           elem_in;
  cmd_t           cmd;
  logic           cmd_valid, cmd_take;
  res_t           res_new, res_head;
  logic           res_push;
  logic [RQ_AW:0] rq_count;

  assign elem_in[0] = elem0_i;
  assign elem_in[1] = elem1_i;
  assign elem_in[2] = elem2_i;
  assign elem_in[3] = elem3_i;

  mct_front #(
    .DIM (DIM)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .action_i (action_i),
    .column_i (column_i),
    .elem_i   (elem_in),
    .valid_o  (cmd_valid),
    .cmd_o    (cmd),
    .take_i   (cmd_take)
  );

  mct_back #(
    .DIM       (DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (cmd_valid),
    .cmd_i       (cmd),
    .take_o      (cmd_take),
    .rq_count_i  (rq_count),
    .res_valid_o (res_push),
    .res_o       (res_new)
  );

  mct_res_q u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (res_new),
    .count_o (rq_count),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (res_head)
  );

  assign out_column_o = res_head.column;
  assign res0_o       = res_head.res[0];
  assign res1_o       = res_head.res[1];
  assign res2_o       = res_head.res[2];
  assign res3_o       = res_head.res[3];
  assign saturated_o  = res_head.sat;

endmodule

// ===== hdl/mct_front.sv =====
`timescale 1ns / 1ps
module mct_front #(
  parameter int unsigned DIM = mct_pkg::DIM_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  output logic                      full_o,
  input  logic                      action_i,
  input  logic [mct_pkg::COL_W-1:0] column_i,
  input  mct_pkg::vec_t             elem_i,
  output logic                      valid_o,
  output mct_pkg::cmd_t             cmd_o,
  input  logic                      take_i
);
  import mct_pkg::*;

  cmd_t             mem_q [IQ_DEPTH];
  logic [IQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [IQ_AW:0]   count_q, count_d;
  logic             accept, keep;
  cmd_t             cmd_in;

  assign full_o  = (count_q == (IQ_AW+1)'(IQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign accept  = push_i & ~full_o;

  // a load aimed past the matrix size is dropped here
  assign keep = accept & ((action_i == ACT_XFORM) || (32'(column_i) < DIM));

  always_comb begin
    cmd_in.kind   = (action_i == ACT_XFORM) ? KIND_XFORM : KIND_LOAD;
    cmd_in.column = column_i;
    cmd_in.elem   = elem_i;
  end

  always_comb begin
    count_d = count_q;
    case ({keep, take_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (keep) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (take_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) mem_q[wr_ptr_q] <= cmd_in;
  end

  a_take_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_o)
    else $error("back took from an empty input queue");

endmodule

// ===== hdl/mct_res_q.sv =====
`timescale 1ns / 1ps
module mct_res_q (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  mct_pkg::res_t             res_i,
  output logic [mct_pkg::RQ_AW:0]   count_o,
  output logic                      empty_o,
  input  logic                      pop_i,
  output mct_pkg::res_t             res_o
);
  import mct_pkg::*;

  res_t             mem_q [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [RQ_AW:0]   count_q, count_d;
  logic             do_pop;

  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign res_o   = mem_q[rd_ptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    count_d = count_q;
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= res_i;
  end

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !push_i) |=> (count_q == $past(count_q) - 1'b1))
    else $error("result count did not drop on pop");

endmodule

// ===== hdl/mct_back.sv =====
`timescale 1ns / 1ps
module mct_back #(
  parameter int unsigned DIM       = mct_pkg::DIM_DEF,
  parameter int unsigned FRAC_BITS = mct_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  mct_pkg::cmd_t           cmd_i,
  output logic                    take_o,
  input  logic [mct_pkg::RQ_AW:0] rq_count_i,
  output logic                    res_valid_o,
  output mct_pkg::res_t           res_o
);
  import mct_pkg::*;

  localparam logic signed [ELEM_W-1:0] RES_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic signed [ELEM_W-1:0] RES_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // left matrix, [column][row], undefined until loaded
  logic [ELEM_W-1:0] lm_q [MAX_DIM][MAX_DIM];

  logic                     s1_v_q;
  logic [COL_W-1:0]         s1_col_q;
  logic signed [PROD_W-1:0] s1_prod_q [MAX_DIM][MAX_DIM];
  logic signed [PROD_W-1:0] prod_d    [MAX_DIM][MAX_DIM];

  logic                     s2_v_q;
  logic [COL_W-1:0]         s2_col_q;
  logic signed [PAIR_W-1:0] s2_pair_q [MAX_DIM][2];
  logic signed [PAIR_W-1:0] pair_d    [MAX_DIM][2];

  logic [RQ_AW+1:0] used;
  logic             room, issue, is_load;

  // results in flight plus results waiting must leave a slot free
  assign used    = (RQ_AW+2)'(rq_count_i) + (RQ_AW+2)'(s1_v_q) + (RQ_AW+2)'(s2_v_q);
  assign room    = (used < (RQ_AW+2)'(RQ_DEPTH));
  assign is_load = (cmd_i.kind == KIND_LOAD);
  assign take_o  = valid_i & (is_load | room);
  assign issue   = take_o & ~is_load;

  always_ff @(posedge clk_i) begin
    if (take_o && is_load) begin
      for (int r = 0; r < MAX_DIM; r++) begin
        if (r < DIM) lm_q[cmd_i.column][r] <= cmd_i.elem[r];
      end
    end
  end

  // rows and terms past the matrix size contribute zero
  always_comb begin
    for (int r = 0; r < MAX_DIM; r++) begin
      for (int j = 0; j < MAX_DIM; j++) begin
        if (r < DIM && j < DIM)
          prod_d[r][j] = $signed(lm_q[j][r]) * $signed(cmd_i.elem[j]);
        else
          prod_d[r][j] = '0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < MAX_DIM; r++) begin
      pair_d[r][0] = {s1_prod_q[r][0][PROD_W-1], s1_prod_q[r][0]}
                   + {s1_prod_q[r][1][PROD_W-1], s1_prod_q[r][1]};
      pair_d[r][1] = {s1_prod_q[r][2][PROD_W-1], s1_prod_q[r][2]}
                   + {s1_prod_q[r][3][PROD_W-1], s1_prod_q[r][3]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_col_q  <= cmd_i.column;
      s1_prod_q <= prod_d;
    end
    if (s1_v_q) begin
      s2_col_q  <= s1_col_q;
      s2_pair_q <= pair_d;
    end
  end

  // final add, floor shift and clip
  always_comb begin
    logic signed [SUM_W-1:0] total;
    logic signed [SUM_W-1:0] shifted;
    logic                    sat_any;
    sat_any = 1'b0;
    res_o.column = s2_col_q;
    for (int r = 0; r < MAX_DIM; r++) begin
      total = {s2_pair_q[r][0][PAIR_W-1], s2_pair_q[r][0]}
            + {s2_pair_q[r][1][PAIR_W-1], s2_pair_q[r][1]};
      shifted = total >>> FRAC_BITS;
      if ((&shifted[SUM_W-1:ELEM_W-1]) || !(|shifted[SUM_W-1:ELEM_W-1])) begin
        res_o.res[r] = shifted[ELEM_W-1:0];
      end else begin
        sat_any = 1'b1;
        res_o.res[r] = shifted[SUM_W-1] ? RES_MIN : RES_MAX;
      end
    end
    res_o.sat = sat_any;
  end

  assign res_valid_o = s2_v_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (rq_count_i != (RQ_AW+1)'(RQ_DEPTH)))
    else $error("result pushed into a full result queue");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.sat) |->
      (res_o.res[0] == RES_MAX || res_o.res[0] == RES_MIN ||
       res_o.res[1] == RES_MAX || res_o.res[1] == RES_MIN ||
       res_o.res[2] == RES_MAX || res_o.res[2] == RES_MIN ||
       res_o.res[3] == RES_MAX || res_o.res[3] == RES_MIN))
    else $error("saturated flag without a clipped row");

endmodule
